// ===== src/agt_pkg.sv =====
// Shared constants for the arm gravity torque pipeline.
// Fixed-point scales, argument reduction and Horner divisor reciprocals.
// No dependencies.
package agt_pkg;

  localparam int unsigned NUM_PARAMS = 7;
  localparam int unsigned ANG_W = 16;
  localparam int unsigned SUM_W = 18;
  localparam int unsigned TRQ_W = 32;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PARAM0 = 3'd1;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint QUARTER_PI = 64'sd843314856;
  localparam longint ROUND30 = 64'sd536870912;
  // 2^50 / (pi/2 in Q.30), quotient estimate scale
  localparam longint KRECIP = 64'sd1125899906842624 / HALF_PI;

  localparam int unsigned TRIG_LAT = 15;
  localparam int unsigned NSIN = 4;
  localparam int unsigned NCOS = 5;

  // floor(x/d) = (x*M) >> S for x < 2^31, M = ceil(2^S/d), S = 31 + ceil(log2 d)
  localparam logic [31:0] SIN_M [NSIN] = '{
    32'(((64'd1 << 38) + 64'd71) / 64'd72),
    32'(((64'd1 << 37) + 64'd41) / 64'd42),
    32'(((64'd1 << 36) + 64'd19) / 64'd20),
    32'(((64'd1 << 34) + 64'd5) / 64'd6)
  };
  localparam int unsigned SIN_S [NSIN] = '{38, 37, 36, 34};
  localparam logic [31:0] COS_M [NCOS] = '{
    32'(((64'd1 << 38) + 64'd89) / 64'd90),
    32'(((64'd1 << 37) + 64'd55) / 64'd56),
    32'(((64'd1 << 36) + 64'd29) / 64'd30),
    32'(((64'd1 << 35) + 64'd11) / 64'd12),
    32'(((64'd1 << 32) + 64'd1) / 64'd2)
  };
  localparam int unsigned COS_S [NCOS] = '{38, 37, 36, 35, 32};

endpackage

// ===== src/agt_trig.sv =====
// Pipelined sine and cosine of a Q6.12 angle, results in Q.30.
// Quadrant reduction, then Horner series.
// Depends on agt_pkg.
module agt_trig (
  input  logic                          clk,
  input  logic                          ce,
  input  logic signed [agt_pkg::SUM_W-1:0] ang,
  output logic signed [31:0]            sin_o,
  output logic signed [31:0]            cos_o
);
  import agt_pkg::*;

  localparam int unsigned RQ_N = 2 * NCOS;

  // reduction
  logic signed [36:0] num_c;
  logic signed [36:0] num1, num2;
  logic signed [37:0] kprod1;
  logic signed [7:0]  kest2;
  logic signed [36:0] kh2;
  logic signed [36:0] r0;
  logic signed [31:0] r3, r4;
  logic [1:0]         quad3, quad4;
  logic [29:0]        r2_4;
  logic signed [63:0] rr;
  logic [63:0]        rr_rnd;

  assign num_c = (37'(ang) <<< 18) + 37'(QUARTER_PI);
  assign r0 = num2 - kh2;
  assign rr = 64'(r3) * 64'(r3);
  assign rr_rnd = $unsigned(rr) + 64'(ROUND30);

  always_ff @(posedge clk) begin
    if (ce) begin
      num1   <= num_c;
      kprod1 <= 38'($signed(num_c[36:20])) * 38'(KRECIP);
      num2   <= num1;
      kest2  <= kprod1[37:30];
      kh2    <= 37'(48'($signed(kprod1[37:30])) * 48'(HALF_PI));
      if (r0 < 0) begin
        r3    <= 32'(r0 + 37'(HALF_PI) - 37'(QUARTER_PI));
        quad3 <= kest2[1:0] - 2'd1;
      end else if (r0 >= 37'(HALF_PI)) begin
        r3    <= 32'(r0 - 37'(HALF_PI) - 37'(QUARTER_PI));
        quad3 <= kest2[1:0] + 2'd1;
      end else begin
        r3    <= 32'(r0 - 37'(QUARTER_PI));
        quad3 <= kest2[1:0];
      end
      r4    <= r3;
      quad4 <= quad3;
      r2_4  <= rr_rnd[59:30];
    end
  end

  // r and quadrant ride alongside the Horner lanes
  logic signed [31:0] rq_r [RQ_N];
  logic [1:0]         rq_q [RQ_N];

  always_ff @(posedge clk) begin
    if (ce) begin
      rq_r[0] <= r4;
      rq_q[0] <= quad4;
      for (int j = 1; j < RQ_N; j++) begin
        rq_r[j] <= rq_r[j-1];
        rq_q[j] <= rq_q[j-1];
      end
    end
  end

  // Horner lanes: each step is mq(r2,t) then t = 1 - x/d
  logic [29:0] s_r2a [NSIN];
  logic [29:0] s_r2b [NSIN];
  logic [30:0] s_x   [NSIN];
  logic [30:0] s_t   [NSIN];
  logic [29:0] c_r2a [NCOS];
  logic [29:0] c_r2b [NCOS];
  logic [30:0] c_x   [NCOS];
  logic [30:0] c_t   [NCOS];

  for (genvar i = 0; i < NSIN; i++) begin : g_sin
    logic [29:0] r2_in;
    logic [30:0] t_in;
    logic [60:0] pa;
    logic [62:0] pb;
    if (i == 0) begin : g_first
      assign r2_in = r2_4;
      assign t_in  = 31'(Q30_ONE);
    end else begin : g_next
      assign r2_in = s_r2b[i-1];
      assign t_in  = s_t[i-1];
    end
    assign pa = 61'(r2_in) * 61'(t_in) + 61'(ROUND30);
    assign pb = 63'(s_x[i]) * 63'(SIN_M[i]);
    always_ff @(posedge clk) begin
      if (ce) begin
        s_x[i]   <= pa[60:30];
        s_r2a[i] <= r2_in;
        s_t[i]   <= 31'(Q30_ONE) - 31'(pb >> SIN_S[i]);
        s_r2b[i] <= s_r2a[i];
      end
    end
  end

  for (genvar i = 0; i < NCOS; i++) begin : g_cos
    logic [29:0] r2_in;
    logic [30:0] t_in;
    logic [60:0] pa;
    logic [62:0] pb;
    if (i == 0) begin : g_first
      assign r2_in = r2_4;
      assign t_in  = 31'(Q30_ONE);
    end else begin : g_next
      assign r2_in = c_r2b[i-1];
      assign t_in  = c_t[i-1];
    end
    assign pa = 61'(r2_in) * 61'(t_in) + 61'(ROUND30);
    assign pb = 63'(c_x[i]) * 63'(COS_M[i]);
    always_ff @(posedge clk) begin
      if (ce) begin
        c_x[i]   <= pa[60:30];
        c_r2a[i] <= r2_in;
        c_t[i]   <= 31'(Q30_ONE) - 31'(pb >> COS_S[i]);
        c_r2b[i] <= c_r2a[i];
      end
    end
  end

  // sin = mq(r, t), then one stage of delay to meet the cos lane
  logic signed [63:0] sp;
  logic signed [31:0] s_fin, s_dly;
  logic signed [31:0] c_fin;

  assign sp = 64'(rq_r[2*NSIN-1]) * 64'(signed'({1'b0, s_t[NSIN-1]})) + 64'(ROUND30);
  assign c_fin = signed'({1'b0, c_t[NCOS-1]});

  always_ff @(posedge clk) begin
    if (ce) begin
      s_fin <= 32'(sp >>> 30);
      s_dly <= s_fin;
      case (rq_q[RQ_N-1])
        2'd0: begin
          sin_o <= s_dly;
          cos_o <= c_fin;
        end
        2'd1: begin
          sin_o <= c_fin;
          cos_o <= -s_dly;
        end
        2'd2: begin
          sin_o <= -s_dly;
          cos_o <= -c_fin;
        end
        default: begin
          sin_o <= -c_fin;
          cos_o <= s_dly;
        end
      endcase
    end
  end

endmodule

// ===== src/arm_gravity_torque.sv =====
// Gravity torques of joints 1 to 4 of a six-joint arm from four joint angles.
// Depends on agt_pkg and agt_trig.
//
// Input stream (s_axis): one transaction carries four Q4.12 joint angles.
// Output stream (m_axis): one transaction per input, four Q16.16 torques,
// each saturated to 32 bits. All four are zero while enable is clear.
// Configuration: cfg_we writes cfg_data to register cfg_addr: 0 enable,
// 1..7 gravity parameters 0..6 (Q16.16). Write only while idle.
// One transaction per cycle is sustained unless the output stalls. Depth:
// the angle-sum register, four parallel trig units (reduction plus nine Horner
// multiply/divide steps in sine and cosine lanes) and three torque stages.
// Reset clears the configuration registers and all pipeline valid bits.
// When m_axis_tready is low with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is dropped or repeated. Empty slots do not
// stall: s_axis_tready stays high while the output stage is empty.
module arm_gravity_torque (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // angle_shoulder, angle_elbow, angle_wrist_one, angle_wrist_two (16 b each)
  input  logic [63:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // torque_shoulder, torque_elbow, torque_wrist_one, torque_wrist_two (32 b each)
  output logic [127:0]                 m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [agt_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [agt_pkg::CFG_DW-1:0]   cfg_data
);
  import agt_pkg::*;

  localparam int unsigned NSTG = 1 + TRIG_LAT + 3;

  logic                     enable;
  logic signed [TRQ_W-1:0]  p [NUM_PARAMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      for (int i = 0; i < NUM_PARAMS; i++) p[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENABLE: enable <= cfg_data[0];
        default:    p[3'(cfg_addr - REG_PARAM0)] <= signed'(cfg_data);
      endcase
    end
  end

  logic [NSTG-1:0] vld;
  logic            adv;

  assign adv = !vld[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], s_axis_tvalid};
    end
  end

  // angle sums
  logic signed [SUM_W-1:0] a1, a12, a123, a4;
  logic signed [ANG_W-1:0] q1, q2, q3, q4;

  assign q1 = signed'(s_axis_tdata[15:0]);
  assign q2 = signed'(s_axis_tdata[31:16]);
  assign q3 = signed'(s_axis_tdata[47:32]);
  assign q4 = signed'(s_axis_tdata[63:48]);

  always_ff @(posedge clk) begin
    if (adv) begin
      a1   <= SUM_W'(q1);
      a12  <= SUM_W'(q1) + SUM_W'(q2);
      a123 <= SUM_W'(q1) + SUM_W'(q2) + SUM_W'(q3);
      a4   <= SUM_W'(q4);
    end
  end

  logic signed [31:0] s1, c1, s12, c12, s123, c123, s4, c4;

  agt_trig u_trig1   (.clk(clk), .ce(adv), .ang(a1),   .sin_o(s1),   .cos_o(c1));
  agt_trig u_trig12  (.clk(clk), .ce(adv), .ang(a12),  .sin_o(s12),  .cos_o(c12));
  agt_trig u_trig123 (.clk(clk), .ce(adv), .ang(a123), .sin_o(s123), .cos_o(c123));
  agt_trig u_trig4   (.clk(clk), .ce(adv), .ang(a4),   .sin_o(s4),   .cos_o(c4));

  // s1 and s12 are not part of the regressor
  logic unused_sin;
  assign unused_sin = ^{s1, s12};

  // stage: wrist cross products
  logic signed [63:0] g3_p, g4_p;
  logic signed [31:0] g3, g4, s123_d, c12_d, c1_d;

  assign g3_p = 64'(s4) * 64'(c123) + 64'(ROUND30);
  assign g4_p = 64'(c4) * 64'(s123) + 64'(ROUND30);

  always_ff @(posedge clk) begin
    if (adv) begin
      g3     <= 32'(g3_p >>> 30);
      g4     <= 32'(g4_p >>> 30);
      s123_d <= s123;
      c12_d  <= c12;
      c1_d   <= c1;
    end
  end

  // stage: regressor terms
  logic signed [32:0] k03, k14, k52;
  logic signed [64:0] m52, m6a, m14, m03, m6b;
  logic signed [34:0] e52, e6a, e14, e03, e6b;

  assign k03 = 33'(p[0]) - 33'(p[3]);
  assign k14 = 33'(p[1]) - 33'(p[4]);
  assign k52 = 33'(p[5]) - 33'(p[2]);
  assign m52 = 65'(k52) * 65'(s123_d) + 65'(ROUND30);
  assign m6a = 65'(p[6]) * 65'(g3) + 65'(ROUND30);
  assign m14 = 65'(k14) * 65'(c12_d) + 65'(ROUND30);
  assign m03 = 65'(k03) * 65'(c1_d) + 65'(ROUND30);
  assign m6b = 65'(p[6]) * 65'(g4) + 65'(ROUND30);

  always_ff @(posedge clk) begin
    if (adv) begin
      e52 <= 35'(m52 >>> 30);
      e6a <= 35'(m6a >>> 30);
      e14 <= 35'(m14 >>> 30);
      e03 <= 35'(m03 >>> 30);
      e6b <= 35'(m6b >>> 30);
    end
  end

  // stage: sums, saturation, output register
  logic signed [37:0] t1, t2, t3, t4;

  function automatic logic [TRQ_W-1:0] sat(input logic signed [37:0] v);
    logic [TRQ_W-1:0] res;
    if (v > 38'sh0_7FFF_FFFF) res = 32'h7FFF_FFFF;
    else if (v < -38'sh0_8000_0000) res = 32'h8000_0000;
    else res = v[TRQ_W-1:0];
    return res;
  endfunction

  assign t3 = 38'(e52) + 38'(e6a);
  assign t2 = t3 + 38'(e14);
  assign t1 = t2 + 38'(e03);
  assign t4 = 38'(e6b);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (enable) begin
        m_axis_tdata <= {sat(t4), sat(t3), sat(t2), sat(t1)};
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

endmodule
